[hw/rtl/mbeb_pkg.sv]
// Shared types and constants of the mask binarize, erode and blank block.
// Used by every module under hw/rtl; depends on nothing.
package mbeb_pkg;

	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 11;
	localparam int COLS_CFG_W  = 11;
	localparam int ROWS_W      = 11;
	localparam int THR_W       = 8;
	localparam int POS_W       = 10;
	localparam int SIZE_W      = 11;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BLANK_X0        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_BLANK_Y0        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BLANK_WIDTH     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_BLANK_HEIGHT    = 3'd6;

	localparam logic [7:0] MASK_ON  = 8'hFF;
	localparam logic [7:0] MASK_OFF = 8'h00;

	typedef struct packed {
		logic [COLS_CFG_W-1:0] frame_cols;
		logic [ROWS_W-1:0]     frame_rows;
		logic [THR_W-1:0]      green_threshold;
		logic [POS_W-1:0]      blank_x0;
		logic [POS_W-1:0]      blank_y0;
		logic [SIZE_W-1:0]     blank_width;
		logic [SIZE_W-1:0]     blank_height;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		frame_cols:      11'd384,
		frame_rows:      11'd384,
		green_threshold: 8'd20,
		blank_x0:        10'd153,
		blank_y0:        10'd118,
		blank_width:     11'd77,
		blank_height:    11'd146
	};

	typedef struct packed {
		logic       cmd;
		logic [7:0] green_value;
	} pixel_t;

	typedef struct packed {
		logic [7:0] mask_value;
		logic       last_of_run;
		logic       end_of_frame;
	} mask_t;

endpackage

[hw/rtl/mbeb_front.sv]
// Front end: accepts pixels, tracks the raster position, keeps the per-column
// row history in a memory and the horizontal window, and classifies results.
// Depends on mbeb_pkg.
module mbeb_front #(
	parameter int MAX_COLS = 1024,
	parameter int ERODE_RADIUS = 5,
	parameter type entry_t = logic
) (
	input  logic            clk,
	input  logic            arst_n,
	input  mbeb_pkg::cfg_t   cfg,
	input  logic            pixel_valid,
	output logic            pixel_stall,
	input  mbeb_pkg::pixel_t pixel,
	output logic            push,
	output entry_t          push_data,
	input  logic            full
);
	import mbeb_pkg::*;

	localparam int R      = ERODE_RADIUS;
	localparam int WIN    = 2 * R + 1;
	localparam int HB     = 2 * R;
	localparam int COL_W  = $clog2(MAX_COLS);
	localparam int COLS_W = $clog2(MAX_COLS + 1);
	localparam int CMP_W  = (COLS_W > COLS_CFG_W) ? COLS_W : COLS_CFG_W;
	localparam int ROW_W  = $clog2((1 << ROWS_W) + R - 1);
	localparam int D_W    = $clog2(R + 1);
	localparam int Y_W    = ROWS_W + 1;
	localparam logic [WIN-1:0] ALL_ONES = '1;

	logic [CMP_W-1:0]  cols_ext;
	logic [COLS_W-1:0] cols_eff;
	logic [COL_W-1:0]  cols_m1;
	logic [ROWS_W-1:0] rows_eff;
	logic [ROW_W-1:0]  last_row;

	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] c_eff;
	logic [ROW_W-1:0] r_eff;
	logic             row_end;
	logic             accept;
	logic             bit_in;

	logic             clr_busy_q;
	logic [COL_W-1:0] clr_addr_q;

	logic [HB-1:0] hist_mem [MAX_COLS];
	logic          mem_we;
	logic [COL_W-1:0] mem_waddr;
	logic [HB-1:0] mem_wdata;

	logic             s1_valid_q;
	logic [COL_W-1:0] c_s1;
	logic [ROW_W-1:0] r_s1;
	logic             bit_s1;
	logic             row_end_s1;
	logic [HB-1:0]    hist_rd_s1;
	logic             byp_hit_s1;
	logic [HB-1:0]    byp_data_s1;

	logic [WIN-1:0] win_q;

	logic [HB-1:0]    hist_s1;
	logic [HB-1:0]    hist_ok;
	logic             vert;
	logic [HB-1:0]    new_hist;
	logic [WIN-1:0]   new_win;
	logic [WIN-1:0]   eff;
	logic [R:0]       res;
	logic             emit;
	logic             s1_go;
	logic             s1_adv;
	logic [D_W-1:0]   d_hi;
	logic [ROWS_W-1:0] yc;
	logic             y_blank;
	logic             y_last;

	assign cols_ext = CMP_W'(cfg.frame_cols);

	always_comb begin
		if (cfg.frame_cols == '0) begin
			cols_eff = COLS_W'(1);
		end else if (cols_ext > CMP_W'(MAX_COLS)) begin
			cols_eff = COLS_W'(MAX_COLS);
		end else begin
			cols_eff = COLS_W'(cols_ext);
		end
	end

	assign cols_m1  = COL_W'(cols_eff - COLS_W'(1));
	assign rows_eff = (cfg.frame_rows == '0) ? ROWS_W'(1) : cfg.frame_rows;
	assign last_row = ROW_W'(rows_eff) + ROW_W'(R - 1);

	assign c_eff   = (col_q > cols_m1) ? cols_m1 : col_q;
	assign r_eff   = (row_q > last_row) ? last_row : row_q;
	assign row_end = (c_eff == cols_m1);
	assign bit_in  = pixel.cmd | (pixel.green_value >= cfg.green_threshold);

	assign s1_go       = ~emit | ~full;
	assign s1_adv      = s1_valid_q & s1_go;
	assign pixel_stall = clr_busy_q | (s1_valid_q & ~s1_go);
	assign accept      = pixel_valid & ~pixel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_q <= '0;
				row_q <= (r_eff >= last_row) ? '0 : r_eff + ROW_W'(1);
			end else begin
				col_q <= c_eff + COL_W'(1);
			end
		end
	end

	// sweep the history memory to all ones after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clr_busy_q) begin
			if (clr_addr_q == COL_W'(MAX_COLS - 1)) begin
				clr_busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + COL_W'(1);
			end
		end
	end

	assign mem_we    = clr_busy_q | s1_adv;
	assign mem_waddr = clr_busy_q ? clr_addr_q : c_s1;
	assign mem_wdata = clr_busy_q ? '1 : new_hist;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			hist_mem[mem_waddr] <= mem_wdata;
		end
		if (accept) begin
			hist_rd_s1 <= hist_mem[c_eff];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_go) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_s1        <= c_eff;
			r_s1        <= r_eff;
			bit_s1      <= bit_in;
			row_end_s1  <= row_end;
			byp_hit_s1  <= s1_adv & (c_s1 == c_eff);
			byp_data_s1 <= new_hist;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '1;
		end else if (s1_adv) begin
			win_q <= new_win;
		end
	end

	assign hist_s1 = byp_hit_s1 ? byp_data_s1 : hist_rd_s1;

	always_comb begin
		for (int i = 0; i < HB; i++) begin
			hist_ok[i] = hist_s1[i] | (r_s1 <= ROW_W'(i));
		end
	end

	assign vert     = bit_s1 & (&hist_ok);
	assign new_hist = {hist_s1[HB-2:0], bit_s1};
	assign new_win  = {win_q[WIN-2:0], vert};

	always_comb begin
		for (int k = 0; k < WIN; k++) begin
			eff[k] = new_win[k] | (32'(k) > 32'(c_s1));
		end
	end

	always_comb begin
		for (int d = 0; d <= R; d++) begin
			res[d] = &(eff | ~(ALL_ONES >> (R - d)));
		end
	end

	assign emit = s1_valid_q & (r_s1 >= ROW_W'(R)) & (row_end_s1 | (c_s1 >= COL_W'(R)));

	always_comb begin
		if (row_end_s1 && (c_s1 < COL_W'(R))) begin
			d_hi = D_W'(c_s1);
		end else begin
			d_hi = D_W'(R);
		end
	end

	assign yc      = ROWS_W'(r_s1 - ROW_W'(R));
	assign y_blank = (Y_W'(yc) >= Y_W'(cfg.blank_y0)) &&
	                 (Y_W'(yc) < Y_W'(cfg.blank_y0) + Y_W'(cfg.blank_height));
	assign y_last  = (yc == rows_eff - ROWS_W'(1));

	assign push = emit;

	always_comb begin
		push_data         = '0;
		push_data.res     = res;
		push_data.d_hi    = d_hi;
		push_data.single  = ~row_end_s1;
		push_data.col     = c_s1;
		push_data.y_blank = y_blank;
		push_data.y_last  = y_last;
	end

endmodule

[hw/rtl/mbeb_queue.sv]
// Short queue of classified result runs between the front and back ends.
// Depends on mbeb_pkg for its depth.
module mbeb_queue #(
	parameter type entry_t = logic
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_data,
	output logic   full,
	input  logic   pop,
	output entry_t head,
	output logic   empty
);
	import mbeb_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	entry_t           slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push & ~full;
	assign do_pop  = pop & ~empty;
	assign head    = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[hw/rtl/mbeb_back.sv]
// Back end: expands each queued run into mask results, applies the footprint
// columns and drives the registered output channel. Depends on mbeb_pkg.
module mbeb_back #(
	parameter int MAX_COLS = 1024,
	parameter int ERODE_RADIUS = 5,
	parameter type entry_t = logic
) (
	input  logic           clk,
	input  logic           arst_n,
	input  mbeb_pkg::cfg_t  cfg,
	input  entry_t         head,
	input  logic           head_valid,
	output logic           pop,
	output logic           mask_valid,
	input  logic           mask_stall,
	output mbeb_pkg::mask_t mask
);
	import mbeb_pkg::*;

	localparam int R     = ERODE_RADIUS;
	localparam int COL_W = $clog2(MAX_COLS);
	localparam int D_W   = $clog2(R + 1);
	localparam int BX_W  = ((COL_W > SIZE_W) ? COL_W : SIZE_W) + 1;

	logic             started_q;
	logic [D_W-1:0]   d_q;
	logic [D_W-1:0]   cur_d;
	logic             last;
	logic             load;
	logic             emit;
	logic [COL_W-1:0] x;
	logic [BX_W-1:0]  x_ext;
	logic             blank;
	logic             on;
	logic             mask_valid_q;
	mask_t            mask_q;

	assign cur_d = started_q ? d_q : head.d_hi;
	assign last  = head.single | (cur_d == '0);
	assign load  = ~mask_valid_q | ~mask_stall;
	assign emit  = head_valid & load;
	assign pop   = emit & last;

	assign x     = head.col - COL_W'(cur_d);
	assign x_ext = BX_W'(x);
	assign blank = head.y_blank && (x_ext >= BX_W'(cfg.blank_x0)) &&
	               (x_ext < BX_W'(cfg.blank_x0) + BX_W'(cfg.blank_width));
	assign on    = head.res[cur_d] & ~blank;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
			d_q       <= '0;
		end else if (emit) begin
			if (last) begin
				started_q <= 1'b0;
			end else begin
				started_q <= 1'b1;
				d_q       <= cur_d - D_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_valid_q <= 1'b0;
		end else if (load) begin
			mask_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			mask_q.mask_value   <= on ? MASK_ON : MASK_OFF;
			mask_q.last_of_run  <= last;
			mask_q.end_of_frame <= head.y_last & ~head.single & (cur_d == '0);
		end
	end

	assign mask_valid = mask_valid_q;
	assign mask       = mask_q;

	a_mask_code: assert property (@(posedge clk) disable iff (!arst_n)
		mask_valid |-> (mask.mask_value == MASK_ON || mask.mask_value == MASK_OFF))
		else $error("mask value is neither on nor off");

	a_eof_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(mask_valid && mask.end_of_frame) |-> mask.last_of_run)
		else $error("frame end inside a run");

	a_run_keeps_head: assert property (@(posedge clk) disable iff (!arst_n)
		started_q |-> head_valid)
		else $error("partly emitted run left the queue");

	a_run_steps_down: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !last) |=> (started_q && d_q == $past(cur_d) - D_W'(1)))
		else $error("run counter did not step");

endmodule

[hw/rtl/mask_binarize_erode_blank_top.sv]
// Top level of the mask binarize, erode and blank block: configuration
// registers, front end, run queue and back end. Depends on mbeb_pkg.
//
// Pixels enter in raster order at one per clock while pixel_stall is low;
// results leave at one per clock while mask_stall is low, ERODE_RADIUS rows
// and ERODE_RADIUS columns behind, with mask_valid rising once the causing
// pixel has passed the front end's stage register, a queue slot and the
// output register. The column history memory (one read and one write per
// clock) sets the input rate of one pixel per cycle when not stalled. The last
// pixel of a row releases a run of up to ERODE_RADIUS+1 results; a four-entry
// queue holds runs while the output port drains them, so on average one result
// per pixel flows without stalling the input. After reset the history memory
// is swept to all ones, during which pixel_stall stays high; configuration writes are taken at any time.
module mask_binarize_erode_blank_top #(
	parameter int MAX_COLS = 1024,
	parameter int ERODE_RADIUS = 5
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pixel_valid,
	output logic                                pixel_stall,
	input  mbeb_pkg::pixel_t                     pixel,
	output logic                                mask_valid,
	input  logic                                mask_stall,
	output mbeb_pkg::mask_t                      mask,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mbeb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [mbeb_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import mbeb_pkg::*;

	localparam int COL_W = $clog2(MAX_COLS);
	localparam int D_W   = $clog2(ERODE_RADIUS + 1);

	typedef struct packed {
		logic [ERODE_RADIUS:0] res;
		logic [D_W-1:0]        d_hi;
		logic                  single;
		logic [COL_W-1:0]      col;
		logic                  y_blank;
		logic                  y_last;
	} entry_t;

	cfg_t   cfg_q;
	logic   push;
	entry_t push_data;
	logic   full;
	logic   pop;
	entry_t head;
	logic   empty;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FRAME_COLS:      cfg_q.frame_cols      <= cfg_data;
				REG_FRAME_ROWS:      cfg_q.frame_rows      <= cfg_data;
				REG_GREEN_THRESHOLD: cfg_q.green_threshold <= cfg_data[THR_W-1:0];
				REG_BLANK_X0:        cfg_q.blank_x0        <= cfg_data[POS_W-1:0];
				REG_BLANK_Y0:        cfg_q.blank_y0        <= cfg_data[POS_W-1:0];
				REG_BLANK_WIDTH:     cfg_q.blank_width     <= cfg_data;
				REG_BLANK_HEIGHT:    cfg_q.blank_height    <= cfg_data;
				default:             cfg_q                 <= cfg_q;
			endcase
		end
	end

	mbeb_front #(
		.MAX_COLS     (MAX_COLS),
		.ERODE_RADIUS (ERODE_RADIUS),
		.entry_t      (entry_t)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.push        (push),
		.push_data   (push_data),
		.full        (full)
	);

	mbeb_queue #(
		.entry_t (entry_t)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.head      (head),
		.empty     (empty)
	);

	mbeb_back #(
		.MAX_COLS     (MAX_COLS),
		.ERODE_RADIUS (ERODE_RADIUS),
		.entry_t      (entry_t)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.head       (head),
		.head_valid (~empty),
		.pop        (pop),
		.mask_valid (mask_valid),
		.mask_stall (mask_stall),
		.mask       (mask)
	);

endmodule

[sim/mask_binarize_erode_blank_checker.sv]
// Scoreboard for the mask binarize, erode and blank block: follows register
// writes and pixel transfers, predicts every mask result and compares it on
// transfer. Depends on mbeb_pkg.
module mask_binarize_erode_blank_checker #(
	parameter int MAX_COLS = 1024,
	parameter int ERODE_RADIUS = 5
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           pixel_valid,
	input  logic                           pixel_stall,
	input  mbeb_pkg::pixel_t               pixel,
	input  logic                           mask_valid,
	input  logic                           mask_stall,
	input  mbeb_pkg::mask_t                mask,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [mbeb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbeb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           closing,
	output int unsigned                    pending,
	output int unsigned                    fail_count
);
	import mbeb_pkg::*;

	localparam int SPAN = 2 * ERODE_RADIUS + 1;
	localparam int DEPTH = 2 * ERODE_RADIUS;
	localparam int REPORT_LIMIT = 10;

	cfg_t             regs;
	logic [DEPTH-1:0] col_hist [MAX_COLS];
	logic [SPAN-1:0]  win_cols;
	int               row_pos;
	int               col_pos;
	mask_t            expected_masks [$];
	int unsigned      mismatches;

	assign fail_count = mismatches + (closing ? pending : 0);

	task automatic predict_masks(input pixel_t px);
		int cols, rows, last_row, r, c, yc, lo, hi, depth, k, j, x;
		logic [DEPTH-1:0] hist, vmask;
		logic fg, vert, acc, row_end;
		mask_t m;
		cols = (regs.frame_cols == 0) ? 1 :
			(regs.frame_cols > MAX_COLS) ? MAX_COLS : int'(regs.frame_cols);
		rows = (regs.frame_rows == 0) ? 1 : int'(regs.frame_rows);
		last_row = rows + ERODE_RADIUS - 1;
		if (col_pos >= cols)
			col_pos = cols - 1;
		if (row_pos > last_row)
			row_pos = last_row;
		r = row_pos;
		c = col_pos;
		fg = px.cmd ? 1'b1 : (px.green_value >= regs.green_threshold);

		hist = col_hist[c];
		depth = (r < DEPTH) ? r : DEPTH;
		vmask = '0;
		for (k = 0; k < depth; k++)
			vmask[k] = 1'b1;
		vert = fg && ((hist & vmask) == vmask);
		col_hist[c] = {hist[DEPTH-2:0], fg};
		win_cols = {win_cols[SPAN-2:0], vert};

		row_end = (c == cols - 1);
		if (r >= ERODE_RADIUS && (row_end || c >= ERODE_RADIUS)) begin
			yc = r - ERODE_RADIUS;
			lo = (c >= ERODE_RADIUS) ? c - ERODE_RADIUS : 0;
			hi = row_end ? c : lo;
			for (x = lo; x <= hi; x++) begin
				acc = 1'b1;
				for (j = x - ERODE_RADIUS; j <= x + ERODE_RADIUS; j++) begin
					if (j >= 0 && j <= c)
						acc = acc & win_cols[c - j];
				end
				if (x >= int'(regs.blank_x0) &&
						x < int'(regs.blank_x0) + int'(regs.blank_width) &&
						yc >= int'(regs.blank_y0) &&
						yc < int'(regs.blank_y0) + int'(regs.blank_height))
					acc = 1'b0;
				m.mask_value = acc ? MASK_ON : MASK_OFF;
				m.last_of_run = (x == hi);
				m.end_of_frame = (yc == rows - 1) && (x == cols - 1);
				expected_masks.insert(expected_masks.size(), m);
			end
		end

		if (row_end) begin
			col_pos = 0;
			row_pos = (r >= last_row) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		mask_t want;
		int k;
		if (!arst_n) begin
			regs = CFG_RESET;
			for (k = 0; k < MAX_COLS; k++)
				col_hist[k] = '1;
			win_cols = '1;
			row_pos = 0;
			col_pos = 0;
			expected_masks.delete();
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRAME_COLS:      regs.frame_cols = cfg_data;
					REG_FRAME_ROWS:      regs.frame_rows = cfg_data;
					REG_GREEN_THRESHOLD: regs.green_threshold = cfg_data[THR_W-1:0];
					REG_BLANK_X0:        regs.blank_x0 = cfg_data[POS_W-1:0];
					REG_BLANK_Y0:        regs.blank_y0 = cfg_data[POS_W-1:0];
					REG_BLANK_WIDTH:     regs.blank_width = cfg_data;
					REG_BLANK_HEIGHT:    regs.blank_height = cfg_data;
					default: ;
				endcase
			end
			if (pixel_valid && !pixel_stall)
				predict_masks(pixel);
			if (mask_valid && !mask_stall) begin
				if (expected_masks.size() == 0) begin
					if (mismatches < REPORT_LIMIT)
						$display("%0t: unexpected mask transfer: value %0d last %0b eof %0b",
							$time, mask.mask_value, mask.last_of_run, mask.end_of_frame);
					mismatches++;
				end else begin
					want = expected_masks.pop_front();
					if (mask.mask_value !== want.mask_value ||
							mask.last_of_run !== want.last_of_run ||
							mask.end_of_frame !== want.end_of_frame) begin
						if (mismatches < REPORT_LIMIT)
							$display({"%0t: mask mismatch: expected value %0d last %0b eof %0b,",
								" got value %0d last %0b eof %0b"}, $time,
								want.mask_value, want.last_of_run, want.end_of_frame,
								mask.mask_value, mask.last_of_run, mask.end_of_frame);
						mismatches++;
					end
				end
			end
		end
		pending = expected_masks.size();
	end

endmodule

[sim/mask_binarize_erode_blank_top_tb.sv]
// Testbench top for mask_binarize_erode_blank_top: drives pixel, mask and
// register channels and gives the verdict. Depends on mbeb_pkg, the block and
// mask_binarize_erode_blank_checker.
module mask_binarize_erode_blank_top_tb;
	import mbeb_pkg::*;

	localparam int ERODE_RADIUS = 5;
	localparam int IDLE_PCT = 38;
	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_PIXELS = 100;
	localparam int CALM_PIXELS = 60;

	logic                  clk;
	logic                  arst_n;
	logic                  pixel_valid;
	logic                  pixel_stall;
	pixel_t                pixel;
	logic                  mask_valid;
	logic                  mask_stall;
	mask_t                 mask;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  calm;
	logic                  closing;
	int unsigned           pending;
	int unsigned           fail_count;
	int unsigned           quiet_cycles;
	int unsigned           pixel_count;
	int unsigned           mask_count;
	int unsigned           frame_count;

	mask_binarize_erode_blank_top dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.mask_valid  (mask_valid),
		.mask_stall  (mask_stall),
		.mask        (mask),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	mask_binarize_erode_blank_checker mask_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.mask_valid  (mask_valid),
		.mask_stall  (mask_stall),
		.mask        (mask),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.closing     (closing),
		.pending     (pending),
		.fail_count  (fail_count)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		mask_stall = 1'b0;
		forever begin
			@(negedge clk);
			mask_stall = !calm && ($urandom_range(99) < IDLE_PCT);
		end
	end

	initial begin
		quiet_cycles = 0;
		pixel_count = 0;
		mask_count = 0;
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if (pixel_valid && !pixel_stall)
				pixel_count++;
			if (mask_valid && !mask_stall)
				mask_count++;
			if ((pixel_valid && !pixel_stall) || (mask_valid && !mask_stall) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("Some tests failed");
		$finish;
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = CFG_DATA_W'(value);
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic push_pixel(input logic cmd, input logic [7:0] green);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			pixel_valid = 1'b0;
			@(negedge clk);
		end
		pixel_valid = 1'b1;
		pixel.cmd = cmd;
		pixel.green_value = green;
		do
			@(posedge clk);
		while (pixel_stall);
		@(negedge clk);
	endtask

	task automatic settle();
		pixel_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	function automatic logic [7:0] pick_green(input int thr, input int fg_pct);
		if (thr == 0)
			return 8'($urandom_range(255, 0));
		if ($urandom_range(99) < fg_pct)
			return 8'($urandom_range(255, thr));
		return 8'($urandom_range(thr - 1, 0));
	endfunction

	task automatic setup_frame(input int cols, input int rows, input int thr,
			input int x0, input int y0, input int w, input int h);
		write_reg(REG_FRAME_COLS, cols);
		write_reg(REG_FRAME_ROWS, rows);
		write_reg(REG_GREEN_THRESHOLD, thr);
		write_reg(REG_BLANK_X0, x0);
		write_reg(REG_BLANK_Y0, y0);
		write_reg(REG_BLANK_WIDTH, w);
		write_reg(REG_BLANK_HEIGHT, h);
		frame_count++;
	endtask

	task automatic run_frame(input int cols, input int rows, input int thr,
			input int fg_pct, input int stop_at);
		int row, col, sent;
		logic cmd;
		sent = 0;
		for (row = 0; row < rows + ERODE_RADIUS; row++) begin
			for (col = 0; col < cols; col++) begin
				if (sent == stop_at)
					return;
				cmd = (row >= rows);
				if ($urandom_range(19) == 0)
					cmd = 1'($urandom_range(1));
				push_pixel(cmd, pick_green(thr, fg_pct));
				sent++;
			end
		end
	endtask

	initial begin
		int cols, rows, thr, total, stop_at, k;
		int unsigned pixels_at;
		arst_n = 1'b0;
		pixel_valid = 1'b0;
		pixel = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		calm = 1'b0;
		closing = 1'b0;
		frame_count = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// degenerate one-pixel frame, everything foreground
		setup_frame(0, 0, 0, 0, 1023, 0, 0);
		push_pixel(1'b0, 8'h00);
		push_pixel(1'b0, 8'hFF);
		push_pixel(1'b1, 8'h00);
		push_pixel(1'b1, 8'hFF);
		push_pixel(1'b0, 8'h55);
		push_pixel(1'b0, 8'hAA);
		settle();

		// top threshold with a footprint covering the whole image
		setup_frame(1, 1, 255, 0, 0, 1024, 1024);
		push_pixel(1'b0, 8'hFF);
		push_pixel(1'b0, 8'hFE);
		push_pixel(1'b1, 8'h00);
		push_pixel(1'b0, 8'hFF);
		push_pixel(1'b1, 8'hFF);
		push_pixel(1'b0, 8'h00);
		settle();

		// shrink the width mid-row
		setup_frame(4, 1, 128, 0, 0, 0, 0);
		push_pixel(1'b0, 8'h80);
		push_pixel(1'b0, 8'h7F);
		settle();
		write_reg(REG_FRAME_COLS, 2);
		push_pixel(1'b1, 8'hFF);
		push_pixel(1'b1, 8'h00);
		push_pixel(1'b1, 8'h12);
		push_pixel(1'b0, 8'h14);
		settle();

		// oversize width acts as the widest frame, then shrink both bounds mid-row
		setup_frame(1, 1024, 20, 1023, 0, 1, 1024);
		for (k = 0; k < ERODE_RADIUS + 1; k++)
			push_pixel(1'b0, pick_green(20, 99));
		settle();
		write_reg(REG_FRAME_COLS, 2047);
		for (k = 0; k < 16; k++)
			push_pixel(1'b0, pick_green(20, 99));
		settle();
		write_reg(REG_FRAME_COLS, 1024);
		for (k = 0; k < 8; k++)
			push_pixel(1'b0, pick_green(20, 98));
		settle();
		write_reg(REG_FRAME_ROWS, 2);
		write_reg(REG_FRAME_COLS, 16);
		for (k = 0; k < 8; k++)
			push_pixel(1'b1, pick_green(20, 98));
		settle();

		pixels_at = pixel_count;
		while (pixel_count - pixels_at < RANDOM_PIXELS) begin
			cols = $urandom_range(12, 1);
			rows = $urandom_range(6, 1);
			case ($urandom_range(9))
				0: thr = 0;
				1: thr = 255;
				default: thr = $urandom_range(254, 1);
			endcase
			setup_frame(cols, rows, thr, $urandom_range(cols, 0), $urandom_range(rows, 0),
				($urandom_range(4) == 0) ? 0 : $urandom_range(cols, 1),
				($urandom_range(4) == 0) ? 0 : $urandom_range(rows, 1));
			total = cols * (rows + ERODE_RADIUS);
			stop_at = ($urandom_range(4) == 0) ? $urandom_range(total - 1, 1) : total;
			calm = (pixel_count - pixels_at < CALM_PIXELS);
			run_frame(cols, rows, thr, $urandom_range(99, 85), stop_at);
			settle();
			calm = 1'b0;
		end

		pixel_valid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (2 * SETTLE_CYCLES) @(negedge clk);
		closing = 1'b1;
		@(negedge clk);
		$display("Run: %0d pixel transfers, %0d mask results, %0d frame setups,",
			pixel_count, mask_count, frame_count);
		$display("  with flush rows, mid-frame resizes, an oversize width and footprint edges.");
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
